/* design/hkt_pkg.sv */
`timescale 1ns / 1ps
package hkt_pkg;

    localparam int HKT_ENTRIES = 768;
    localparam int HKT_THREADS = 4;
    localparam int HKT_HEIGHTS = 64;

    localparam logic [14:0] PROB_ONE = 15'd16384;
    localparam int PROB_BITS = 14;

    localparam logic [15:0] SCORE_LIMIT_RST = 16'd32768;
    localparam logic [15:0] COUNT_LIMIT_RST = 16'd16384;
    localparam logic [10:0] EVAL_CLAMP_RST = 11'd1000;

    localparam logic [1:0] REG_SCORE_LIMIT = 2'd0;
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd1;
    localparam logic [1:0] REG_EVAL_CLAMP = 2'd2;

    localparam logic [1:0] KIND_GOOD = 2'd0;
    localparam logic [1:0] KIND_BAD = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_SWEEP,
        ST_DIVGO,
        ST_DIV,
        ST_DONE
    } state_t;

    // halve, rounding away from zero
    function automatic logic signed [17:0] halve_away(input logic signed [17:0] x);
        logic signed [18:0] t;
        begin
            t = {x[17], x};
            if (!x[17])
                t = t + 19'sd1;
            halve_away = t[18:1];
        end
    endfunction

    function automatic logic [15:0] halve_up(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x} + 17'd1;
            halve_up = t[16:1];
        end
    endfunction

endpackage

/* design/hkt_if.sv */
`timescale 1ns / 1ps
interface hkt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         piece_code;
    logic [5:0]         target_square;
    logic [15:0]        move_code;
    logic               excluded;
    logic [5:0]         depth;
    logic [5:0]         ply;
    logic [1:0]         thread_id;
    logic               cutoff;
    logic signed [15:0] eval;

    modport source (output valid, kind, piece_code, target_square, move_code, excluded,
                    depth, ply, thread_id, cutoff, eval, input ready);
    modport sink (input valid, kind, piece_code, target_square, move_code, excluded,
                  depth, ply, thread_id, cutoff, eval, output ready);
endinterface

interface hkt_res_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] history_score;
    logic signed [12:0] eval_value;
    logic [14:0]        hit_probability;
    logic [15:0]        killer_first;
    logic [15:0]        killer_second;

    modport source (output valid, history_score, eval_value, hit_probability,
                    killer_first, killer_second, input ready);
    modport sink (input valid, history_score, eval_value, hit_probability,
                  killer_first, killer_second, output ready);
endinterface

/* design/history_killer_table_core.sv */
`timescale 1ns / 1ps
// Steps for a request: load, calc, divider start, divide, done; the divider iterates only when
// 0 < total and hit < total. A score overflow adds a halving sweep over the score RAM after calc.
// A new request is taken only in idle, once the previous result has gone into the output register,
// so requests do not overlap.
// Reset: registers to their defaults, then a clearing pass over every score, count, eval and killer
// entry during which no request is taken.
module history_killer_table_core
    import hkt_pkg::*;
#(
    parameter int ENTRIES = HKT_ENTRIES,
    parameter int THREADS = HKT_THREADS,
    parameter int HEIGHTS = HKT_HEIGHTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    hkt_req_if.sink     request,
    hkt_res_if.source   result
);
    localparam int AW = $clog2(ENTRIES);
    localparam int KD = THREADS * HEIGHTS;
    localparam int KAW = $clog2(KD);
    localparam int CLR_N = (ENTRIES > KD) ? ENTRIES : KD;
    localparam int CW = $clog2(CLR_N + 1);

    state_t state_reg, state_next;

    logic [15:0] score_limit_reg, count_limit_reg;
    logic [10:0] eval_clamp_reg;

    logic [CW-1:0] cnt_reg, cnt_next;

    logic [1:0]  kind_reg;
    logic [AW-1:0] addr_reg;
    logic [KAW-1:0] kaddr_reg;
    logic        entry_ok_reg, killer_ok_reg, excl_reg, cutoff_reg;
    logic [15:0] move_reg;
    logic [5:0]  depth_reg;
    logic [11:0] inc_reg;
    logic signed [15:0] eval_reg;

    logic signed [17:0] res_score_reg, res_score_next;
    logic signed [11:0] res_eval_reg, res_eval_next;
    logic [15:0] res_hit_reg, res_hit_next, res_total_reg, res_total_next;
    logic [15:0] res_k0_reg, res_k0_next, res_k1_reg, res_k1_next;

    logic        out_valid_reg;
    logic signed [16:0] out_score_reg;
    logic signed [12:0] out_eval_reg;
    logic [14:0] out_prob_reg;
    logic [15:0] out_k0_reg, out_k1_reg;

    logic        score_we, cnt_we, eval_we, kill_we;
    logic [AW-1:0] score_waddr, score_raddr, tab_waddr;
    logic [17:0] score_wdata, score_rdata;
    logic [15:0] hit_wdata, hit_rdata, total_wdata, total_rdata;
    logic [11:0] eval_wdata, eval_rdata;
    logic [KAW-1:0] kill_waddr;
    logic [15:0] k0_wdata, k0_rdata, k1_wdata, k1_rdata;

    logic        div_start, div_done;
    logic [14:0] div_q;

    logic [9:0]  req_idx;
    logic        take, out_load;
    logic        halve_hit;

    logic signed [17:0] inc_s, lim_s, new_score;
    logic [15:0] h_upd, t_upd;
    logic signed [16:0] c_s, ev17, v17;
    logic signed [11:0] v12, best;

    hkt_ram #(.WIDTH(18), .DEPTH(ENTRIES)) u_score (
        .clk(clk), .we(score_we), .waddr(score_waddr), .wdata(score_wdata),
        .raddr(score_raddr), .rdata(score_rdata));
    hkt_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_hit (
        .clk(clk), .we(cnt_we), .waddr(tab_waddr), .wdata(hit_wdata),
        .raddr(addr_reg), .rdata(hit_rdata));
    hkt_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_total (
        .clk(clk), .we(cnt_we), .waddr(tab_waddr), .wdata(total_wdata),
        .raddr(addr_reg), .rdata(total_rdata));
    hkt_ram #(.WIDTH(12), .DEPTH(ENTRIES)) u_eval (
        .clk(clk), .we(eval_we), .waddr(tab_waddr), .wdata(eval_wdata),
        .raddr(addr_reg), .rdata(eval_rdata));
    hkt_ram #(.WIDTH(16), .DEPTH(KD)) u_kill0 (
        .clk(clk), .we(kill_we), .waddr(kill_waddr), .wdata(k0_wdata),
        .raddr(kaddr_reg), .rdata(k0_rdata));
    hkt_ram #(.WIDTH(16), .DEPTH(KD)) u_kill1 (
        .clk(clk), .we(kill_we), .waddr(kill_waddr), .wdata(k1_wdata),
        .raddr(kaddr_reg), .rdata(k1_rdata));

    hkt_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .hit(res_hit_reg), .total(res_total_reg),
        .done(div_done), .quotient(div_q));

    assign req_idx = {request.piece_code, request.target_square};
    assign request.ready = (state_reg == ST_IDLE);
    assign take = request.valid && request.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            score_limit_reg <= SCORE_LIMIT_RST;
            count_limit_reg <= COUNT_LIMIT_RST;
            eval_clamp_reg  <= EVAL_CLAMP_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SCORE_LIMIT: score_limit_reg <= cfg_data;
                    REG_COUNT_LIMIT: count_limit_reg <= cfg_data;
                    REG_EVAL_CLAMP:  eval_clamp_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg      <= request.kind;
            addr_reg      <= AW'(req_idx);
            entry_ok_reg  <= ({22'd0, req_idx} < 32'(ENTRIES));
            killer_ok_reg <= (32'(request.thread_id) < 32'(THREADS))
                             && (32'(request.ply) < 32'(HEIGHTS));
            kaddr_reg     <= KAW'(32'(request.thread_id) * 32'(HEIGHTS) + 32'(request.ply));
            excl_reg      <= request.excluded;
            cutoff_reg    <= request.cutoff;
            move_reg      <= request.move_code;
            depth_reg     <= request.depth;
            eval_reg      <= request.eval;
        end
        if (state_reg == ST_LOAD)
            inc_reg <= 12'(depth_reg) * 12'(depth_reg);
        res_score_reg <= res_score_next;
        res_eval_reg  <= res_eval_next;
        res_hit_reg   <= res_hit_next;
        res_total_reg <= res_total_next;
        res_k0_reg    <= res_k0_next;
        res_k1_reg    <= res_k1_next;
        if (out_load)
        begin
            if (res_score_reg > 18'sd65535)
                out_score_reg <= 17'sd65535;
            else if (res_score_reg < -18'sd65535)
                out_score_reg <= -17'sd65535;
            else
                out_score_reg <= res_score_reg[16:0];
            out_eval_reg <= entry_ok_reg ? {res_eval_reg[11], res_eval_reg} : '0;
            out_prob_reg <= entry_ok_reg ? div_q : '0;
            out_k0_reg   <= killer_ok_reg ? res_k0_reg : '0;
            out_k1_reg   <= killer_ok_reg ? res_k1_reg : '0;
        end
    end

    // update datapath
    always_comb
    begin
        inc_s = $signed({6'd0, inc_reg});
        lim_s = $signed({2'd0, score_limit_reg});
        new_score = $signed(score_rdata);
        h_upd = hit_rdata;
        t_upd = total_rdata;
        best = $signed(eval_rdata);
        c_s = $signed({6'd0, eval_clamp_reg});
        ev17 = {eval_reg[15], eval_reg};
        halve_hit = 1'b0;
        if (ev17 > c_s)
            v17 = c_s;
        else if (ev17 < -c_s)
            v17 = -c_s;
        else
            v17 = ev17;
        v12 = v17[11:0];
        if (!excl_reg && kind_reg == KIND_GOOD)
        begin
            new_score = $signed(score_rdata) + inc_s;
            halve_hit = new_score > lim_s;
            if (cutoff_reg)
            begin
                h_upd = hit_rdata + 16'd1;
                t_upd = total_rdata + 16'd1;
            end
        end
        else if (!excl_reg && kind_reg == KIND_BAD)
        begin
            new_score = $signed(score_rdata) - inc_s;
            halve_hit = new_score < -lim_s;
            t_upd = total_rdata + 16'd1;
        end
        if (t_upd >= count_limit_reg && t_upd != total_rdata)
        begin
            h_upd = halve_up(h_upd);
            t_upd = halve_up(t_upd);
        end
        if (!excl_reg && kind_reg == KIND_EVAL)
        begin
            if (v12 >= best)
                best = (v12 == 12'sd0) ? 12'sd1 : v12;
            else if (17'(best) > -c_s)
                best = (best == 12'sd1) ? -12'sd1 : best - 12'sd1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_score_next = res_score_reg;
        res_eval_next  = res_eval_reg;
        res_hit_next   = res_hit_reg;
        res_total_next = res_total_reg;
        res_k0_next    = res_k0_reg;
        res_k1_next    = res_k1_reg;
        score_we    = 1'b0;
        cnt_we      = 1'b0;
        eval_we     = 1'b0;
        kill_we     = 1'b0;
        score_waddr = addr_reg;
        score_raddr = addr_reg;
        tab_waddr   = addr_reg;
        kill_waddr  = kaddr_reg;
        score_wdata = new_score;
        hit_wdata   = h_upd;
        total_wdata = t_upd;
        eval_wdata  = best;
        k0_wdata    = move_reg;
        k1_wdata    = k0_rdata;
        div_start   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                score_waddr = AW'(cnt_reg);
                tab_waddr   = AW'(cnt_reg);
                kill_waddr  = KAW'(cnt_reg);
                score_wdata = '0;
                hit_wdata   = 16'd1;
                total_wdata = 16'd1;
                eval_wdata  = '0;
                k0_wdata    = '0;
                k1_wdata    = '0;
                score_we = (32'(cnt_reg) < 32'(ENTRIES));
                cnt_we   = score_we;
                eval_we  = score_we;
                kill_we  = (32'(cnt_reg) < 32'(KD));
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == 32'(CLR_N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
                if (take)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_CALC;
            ST_CALC:
            begin
                score_we = entry_ok_reg && !excl_reg
                           && (kind_reg == KIND_GOOD || kind_reg == KIND_BAD);
                cnt_we   = score_we;
                eval_we  = entry_ok_reg && !excl_reg && kind_reg == KIND_EVAL;
                kill_we  = killer_ok_reg && !excl_reg && kind_reg == KIND_GOOD
                           && k0_rdata != move_reg;
                res_score_next = entry_ok_reg ? new_score : '0;
                res_eval_next  = entry_ok_reg ? best : '0;
                res_hit_next   = entry_ok_reg ? h_upd : '0;
                res_total_next = entry_ok_reg ? t_upd : '0;
                res_k0_next    = kill_we ? move_reg : k0_rdata;
                res_k1_next    = kill_we ? k0_rdata : k1_rdata;
                cnt_next = '0;
                if (entry_ok_reg && halve_hit)
                    state_next = ST_SWEEP;
                else
                    state_next = ST_DIVGO;
            end
            ST_SWEEP:
            begin
                // read entry n, write back entry n-1
                score_raddr = AW'(cnt_reg);
                score_waddr = AW'(cnt_reg - 1'b1);
                score_wdata = halve_away($signed(score_rdata));
                score_we    = (cnt_reg != '0);
                cnt_next    = cnt_reg + 1'b1;
                if (32'(cnt_reg) == 32'(ENTRIES))
                begin
                    cnt_next       = '0;
                    res_score_next = halve_away(res_score_reg);
                    state_next     = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign result.valid           = out_valid_reg;
    assign result.history_score   = out_score_reg;
    assign result.eval_value      = out_eval_reg;
    assign result.hit_probability = out_prob_reg;
    assign result.killer_first    = out_k0_reg;
    assign result.killer_second   = out_k1_reg;

    property p_no_take_clear;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_CLEAR) |-> !request.ready;
    endproperty
    a_no_take_clear: assert property (p_no_take_clear) else $error("request during clear");

    property p_idle_no_write;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_IDLE) |-> !(score_we || cnt_we || eval_we || kill_we);
    endproperty
    a_idle_no_write: assert property (p_idle_no_write) else $error("write while idle");

    property p_out_after_done;
        @(posedge clk) disable iff (!rst_n) $rose(out_valid_reg) |-> $past(state_reg == ST_DONE);
    endproperty
    a_out_after_done: assert property (p_out_after_done) else $error("result out of sequence");

    property p_prob_cap;
        @(posedge clk) disable iff (!rst_n) out_valid_reg |-> (out_prob_reg <= PROB_ONE);
    endproperty
    a_prob_cap: assert property (p_prob_cap) else $error("probability above cap");
endmodule

/* design/hkt_ram.sv */
`timescale 1ns / 1ps
module hkt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* design/hkt_div.sv */
`timescale 1ns / 1ps
module hkt_div
    import hkt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] hit,
    input  logic [15:0] total,
    output logic        done,
    output logic [14:0] quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [14:0] q_reg, q_next;
    logic [16:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        shifted   = {rem_reg[15:0], 1'b0};
        if (start)
        begin
            den_next = total;
            rem_next = {1'b0, hit};
            q_next   = '0;
            cnt_next = 4'(PROB_BITS);
            if (total == 16'd0)
                done_next = 1'b1;
            else if (hit >= total)
            begin
                q_next    = PROB_ONE;
                done_next = 1'b1;
            end
            else
                busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[13:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[13:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !start;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("div restarted");

    property p_q_cap;
        @(posedge clk) disable iff (!rst_n) done_reg |-> (q_reg <= PROB_ONE);
    endproperty
    a_q_cap: assert property (p_q_cap) else $error("quotient above cap");

    property p_done_end;
        @(posedge clk) disable iff (!rst_n) $fell(busy_reg) |-> done_reg;
    endproperty
    a_done_end: assert property (p_done_end) else $error("div ended without done");
endmodule
